@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge and muted while reset is held.
`define CFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CFQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CFQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cfq_pkg.sv @@
// Types and constants shared by the circular queue files.
package cfq_pkg;

	localparam int HANDLE_W = 32;
	localparam int COUNT_W  = 7;
	localparam int FUNC_W   = 2;

	// Operation codes of the func field; the unused code acts as a query
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic                status;
		logic [HANDLE_W-1:0] pop_value;
		logic [HANDLE_W-1:0] front_value;
		logic [HANDLE_W-1:0] back_value;
		logic [COUNT_W-1:0]  entry_count;
		logic                is_empty;
		logic                is_full;
	} rsp_t;

endpackage

@@ hw/rtl/cfq_if.sv @@
// Request and result channel interfaces of the circular queue.
interface cfq_req_if import cfq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [HANDLE_W-1:0] push_value;

	modport source (output valid, func, push_value, input ready);
	modport sink (input valid, func, push_value, output ready);
endinterface

interface cfq_rsp_if import cfq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                status;
	logic [HANDLE_W-1:0] pop_value;
	logic [HANDLE_W-1:0] front_value;
	logic [HANDLE_W-1:0] back_value;
	logic [COUNT_W-1:0]  entry_count;
	logic                is_empty;
	logic                is_full;

	modport source (output valid, status, pop_value, front_value, back_value,
		entry_count, is_empty, is_full, input ready);
	modport sink (input valid, status, pop_value, front_value, back_value,
		entry_count, is_empty, is_full, output ready);
endinterface

@@ hw/rtl/circular_fifo_queue.sv @@
// Circular queue of 32-bit handles, one slot always kept free (DEPTH-1 usable).
// Result: registered from the accepted item; a pop leaving one or more handles first goes
//   through the read state, where the registered slot memory read delivers the new front.
// Throughput: one push or query per cycle while the result slot is free, none in ST_READ.
// Reset: pointers, count, sequencer and result valid clear asynchronously;
//   slot memory contents stay undefined until written.
module circular_fifo_queue import cfq_pkg::*; #(
	parameter int DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	cfq_req_if.sink    req,
	cfq_rsp_if.source  rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                rsp_valid_q;
	rsp_t                rsp_q;
	rsp_t                res;
	logic                res_load;
	logic                slot_free;
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [HANDLE_W-1:0] mem_wdata, mem_rdata;

	assign slot_free = !rsp_valid_q || rsp.ready;

	cfq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req.valid),
		.req_func       (req.func),
		.req_push_value (req.push_value),
		.req_ready      (req.ready),
		.slot_free      (slot_free),
		.res_load       (res_load),
		.res            (res),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_re         (mem_re),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

	cfq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.pop_value   = rsp_q.pop_value;
	assign rsp.front_value = rsp_q.front_value;
	assign rsp.back_value  = rsp_q.back_value;
	assign rsp.entry_count = rsp_q.entry_count;
	assign rsp.is_empty    = rsp_q.is_empty;
	assign rsp.is_full     = rsp_q.is_full;

endmodule

@@ hw/rtl/cfq_ram.sv @@
// Slot memory: one write port, one read port with registered read data.
module cfq_ram import cfq_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [HANDLE_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [HANDLE_W-1:0] rdata
);

	logic [HANDLE_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/cfq_ctrl.sv @@
// Queue control: head/tail pointers, count, cached front/back and pop sequencing.
module cfq_ctrl import cfq_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [FUNC_W-1:0]   req_func,
	input  logic [HANDLE_W-1:0] req_push_value,
	output logic                req_ready,
	input  logic                slot_free,
	output logic                res_load,
	output rsp_t                res,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [HANDLE_W-1:0] mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	input  logic [HANDLE_W-1:0] mem_rdata
);

	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [AW-1:0] MAX_CNT  = AW'(DEPTH - 1);

	state_t              state_q, state_nx;
	logic [AW-1:0]       head_q, head_nx;
	logic [AW-1:0]       tail_q, tail_nx;
	logic [AW-1:0]       count_q, count_nx;
	logic [HANDLE_W-1:0] front_q, front_nx;
	logic [HANDLE_W-1:0] back_q, back_nx;
	logic [HANDLE_W-1:0] pop_q, pop_nx;
	logic                status_nx;
	logic                accept;
	logic                empty_q, full_q, empty_nx;
	logic [AW-1:0]       head_inc, tail_inc;

	// Wrapping increments and current flags
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
	assign empty_q  = (count_q == '0);
	assign full_q   = (count_q == MAX_CNT);
	assign accept   = req_valid && req_ready;

	// Datapath: apply the operation, issue slot accesses
	always_comb begin
		head_nx   = head_q;
		tail_nx   = tail_q;
		count_nx  = count_q;
		front_nx  = front_q;
		back_nx   = back_q;
		pop_nx    = '0;
		status_nx = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = req_push_value;
		mem_re    = 1'b0;
		mem_raddr = head_inc;
		if (state_q == ST_READ) begin
			// new front arrives from the slot memory
			front_nx = mem_rdata;
			pop_nx   = pop_q;
		end else if (accept) begin
			case (req_func)
				FUNC_PUSH: begin
					if (req_push_value == '0 || full_q) begin
						status_nx = 1'b1;
					end else begin
						mem_we   = 1'b1;
						tail_nx  = tail_inc;
						count_nx = count_q + AW'(1);
						back_nx  = req_push_value;
						if (empty_q) begin
							front_nx = req_push_value;
						end
					end
				end
				FUNC_POP: begin
					if (empty_q) begin
						status_nx = 1'b1;
					end else begin
						pop_nx   = front_q;
						head_nx  = head_inc;
						count_nx = count_q - AW'(1);
						// fetch the next front unless the queue drains
						mem_re   = (count_q > AW'(1));
					end
				end
				FUNC_QUERY: ;
				default: ;
			endcase
		end
	end

	// Result as it stands after the operation
	always_comb begin
		empty_nx        = (count_nx == '0);
		res.status      = status_nx;
		res.pop_value   = pop_nx;
		res.front_value = empty_nx ? '0 : front_nx;
		res.back_value  = empty_nx ? '0 : back_nx;
		res.entry_count = COUNT_W'(count_nx);
		res.is_empty    = empty_nx;
		res.is_full     = (count_nx == MAX_CNT);
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (mem_re) begin
					state_nx = ST_READ;
				end
			end
			ST_READ: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		req_ready = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = slot_free;
				res_load  = accept && !mem_re;
			end
			ST_READ: res_load = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_nx;
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			count_q <= count_nx;
		end
	end

	// Cached handles
	always_ff @(posedge clk) begin
		front_q <= front_nx;
		back_q  <= back_nx;
		pop_q   <= pop_nx;
	end

endmodule

@@ hw/rtl/cfq_checker.sv @@
// Port-level checks of the circular queue, bound to the top level.
`include "assert_macros.svh"

module cfq_checker import cfq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                status,
	input logic [HANDLE_W-1:0] pop_value,
	input logic [HANDLE_W-1:0] front_value,
	input logic [HANDLE_W-1:0] back_value,
	input logic [COUNT_W-1:0]  entry_count,
	input logic                is_empty,
	input logic                is_full
);

	// A stalled result item keeps its valid, pop value, front value and count
	`CFQ_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(pop_value) && $stable(front_value) && $stable(entry_count), "result item changed while stalled")

	// An empty queue shows null front and back and a zero count
	`CFQ_ASSERT_IMP(a_empty_null, clk, arst_n, rsp_valid && is_empty, front_value == '0 && back_value == '0 && entry_count == '0, "empty queue shows handles")

	// A rejected operation removes nothing
	`CFQ_ASSERT_IMP(a_reject_nopop, clk, arst_n, rsp_valid && status, pop_value == '0, "rejected item returned a handle")

	// Empty and full never coincide
	`CFQ_ASSERT(a_flags_excl, clk, arst_n, !(rsp_valid && is_empty && is_full), "queue both empty and full")

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.pop_value   (rsp.pop_value),
	.front_value (rsp.front_value),
	.back_value  (rsp.back_value),
	.entry_count (rsp.entry_count),
	.is_empty    (rsp.is_empty),
	.is_full     (rsp.is_full)
);

@@ verif/tb.sv @@
// Testbench for circular_fifo_queue: shadow ring-buffer predictor, random handshakes.
module tb;
	import cfq_pkg::*;

	localparam int DEPTH          = 128;
	localparam int IDX_W          = $clog2(DEPTH);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	// spare operation code, the block treats it as a query
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	logic clk;
	logic arst_n;

	cfq_req_if req_ch();
	cfq_rsp_if rsp_ch();

	circular_fifo_queue #(.DEPTH(DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the ring buffer
	logic [HANDLE_W-1:0] shadow_slots [DEPTH];
	int unsigned         shadow_head;
	int unsigned         shadow_tail;

	rsp_t pending_results [$];
	int   fail_count;
	int   quiet_cycles;
	int   rx_hold_left;
	int   rx_stall_left;
	bit   no_gaps;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned ring_next(input int unsigned idx);
		return (idx + 1 == DEPTH) ? 0 : idx + 1;
	endfunction

	function automatic int unsigned shadow_count();
		return (shadow_tail + DEPTH - shadow_head) % DEPTH;
	endfunction

	// apply one operation to the shadow queue and return what the block should report
	function automatic rsp_t queue_step(input logic [FUNC_W-1:0] op,
			input logic [HANDLE_W-1:0] handle);
		rsp_t        res;
		int unsigned cnt;
		res = '0;
		case (op)
			FUNC_PUSH: begin
				if (handle == '0 || ring_next(shadow_tail) == shadow_head) begin
					res.status = 1'b1;
				end else begin
					shadow_slots[IDX_W'(shadow_tail)] = handle;
					shadow_tail = ring_next(shadow_tail);
				end
			end
			FUNC_POP: begin
				if (shadow_head == shadow_tail) begin
					res.status = 1'b1;
				end else begin
					res.pop_value = shadow_slots[IDX_W'(shadow_head)];
					shadow_head = ring_next(shadow_head);
				end
			end
			default: ;
		endcase
		cnt = shadow_count();
		if (cnt != 0) begin
			res.front_value = shadow_slots[IDX_W'(shadow_head)];
			res.back_value  = shadow_slots[IDX_W'((shadow_tail == 0) ? DEPTH - 1
				: shadow_tail - 1)];
		end
		res.entry_count = cnt[COUNT_W-1:0];
		res.is_empty    = (cnt == 0);
		res.is_full     = (cnt == DEPTH - 1);
		return res;
	endfunction

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_handle();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_live_handle();
		logic [HANDLE_W-1:0] h;
		h = $urandom;
		return (h == '0) ? 32'd1 : h;
	endfunction

	function automatic logic [FUNC_W-1:0] pick_func(input int push_pct);
		case ($urandom_range(0, 19))
			0: return FUNC_QUERY;
			1: return FUNC_SPARE;
			default: return ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [HANDLE_W-1:0] want,
			input logic [HANDLE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// predict on each accepted item, compare each accepted result
	always @(posedge clk) begin
		rsp_t want;
		if (req_ch.valid && req_ch.ready)
			pending_results.push_back(queue_step(req_ch.func, req_ch.push_value));
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result arrived with nothing pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", HANDLE_W'(want.status), HANDLE_W'(rsp_ch.status));
				check_field("pop_value", want.pop_value, rsp_ch.pop_value);
				check_field("front_value", want.front_value, rsp_ch.front_value);
				check_field("back_value", want.back_value, rsp_ch.back_value);
				check_field("entry_count", HANDLE_W'(want.entry_count),
					HANDLE_W'(rsp_ch.entry_count));
				check_field("is_empty", HANDLE_W'(want.is_empty),
					HANDLE_W'(rsp_ch.is_empty));
				check_field("is_full", HANDLE_W'(want.is_full), HANDLE_W'(rsp_ch.is_full));
			end
		end
	end

	// result side ready: long hold when asked, otherwise random stalls
	always @(posedge clk) begin
		int stall;
		if (rx_hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			rx_hold_left--;
		end else if (rx_stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			rx_stall_left--;
		end else begin
			stall = pick_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_stall_left = stall - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// offer one item and hold it until taken, then maybe idle
	task automatic send_item(input logic [FUNC_W-1:0] op, input logic [HANDLE_W-1:0] handle);
		int gap;
		req_ch.valid      <= 1'b1;
		req_ch.func       <= op;
		req_ch.push_value <= handle;
		do @(posedge clk); while (!req_ch.ready);
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// field extremes, every operation and the null-push and empty-pop rejects
	task automatic test_directed();
		send_item(FUNC_QUERY, '0);
		send_item(FUNC_POP, '1);
		send_item(FUNC_PUSH, '0);
		send_item(FUNC_SPARE, 32'h5A5A_A5A5);
		send_item(FUNC_PUSH, '1);
		send_item(FUNC_PUSH, 32'd1);
		send_item(FUNC_PUSH, 32'h8000_0000);
		send_item(FUNC_PUSH, 32'h7FFF_FFFF);
		send_item(FUNC_QUERY, '1);
		send_item(FUNC_SPARE, '0);
		send_item(FUNC_PUSH, '0);
		send_item(FUNC_POP, '0);
		send_item(FUNC_POP, '1);
		send_item(FUNC_POP, '0);
		send_item(FUNC_POP, '0);
		send_item(FUNC_POP, '0);
		send_item(FUNC_PUSH, 32'hA5A5_5A5A);
		send_item(FUNC_POP, '0);
		send_item(FUNC_QUERY, '0);
		wait_drained();
	endtask

	// fill to full, try pushing past it, then drain past empty
	task automatic test_fill_and_drain();
		int need;
		wait_drained();
		need = DEPTH - 1 - shadow_count();
		repeat (need)
			send_item(FUNC_PUSH, pick_live_handle());
		send_item(FUNC_PUSH, pick_live_handle());
		send_item(FUNC_PUSH, '0);
		send_item(FUNC_QUERY, $urandom);
		send_item(FUNC_SPARE, $urandom);
		repeat (DEPTH)
			send_item(FUNC_POP, $urandom);
		wait_drained();
	endtask

	// result side blocked for a long stretch while items keep coming
	task automatic test_backpressure();
		no_gaps = 1'b1;
		rx_hold_left = HOLD_CYCLES;
		repeat (24)
			send_item(FUNC_PUSH, pick_live_handle());
		repeat (16)
			send_item(pick_func(30), pick_handle());
		no_gaps = 1'b0;
		wait_drained();
	endtask

	// bursts biased towards filling, emptying or mixed traffic
	task automatic test_random_traffic(input int n_items);
		int sent;
		int burst;
		int push_pct;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(10, 60);
			if (burst > n_items - sent)
				burst = n_items - sent;
			case ($urandom_range(0, 3))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (burst) begin
				send_item(pick_func(push_pct), pick_handle());
				sent++;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.func       = FUNC_QUERY;
		req_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;
		shadow_head       = 0;
		shadow_tail       = 0;
		fail_count        = 0;
		quiet_cycles      = 0;
		rx_hold_left      = 0;
		rx_stall_left     = 0;
		no_gaps           = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_backpressure();
		test_random_traffic(240);

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
